### design/tcpct_pkg.sv
`default_nettype none
package tcpct_pkg;

   // Default geometry of the table.
   localparam int INDEX_BITS_DEF = 10;
   localparam int WAYS_DEF       = 4;

   // Width of the reported counters.
   localparam int COUNT_W = 13;

   // Width of a way number in the match summary; covers up to sixteen ways.
   localparam int WAY_IDX_W = 4;

   // Operation codes.
   localparam logic [2:0] FUNC_LOOKUP  = 3'd0;
   localparam logic [2:0] FUNC_UPSERT  = 3'd1;
   localparam logic [2:0] FUNC_REMOVE  = 3'd2;
   localparam logic [2:0] FUNC_PURGE   = 3'd3;
   localparam logic [2:0] FUNC_SET_PC  = 3'd4;
   localparam logic [2:0] FUNC_GET_PC  = 3'd5;

   // One slot of the table.
   typedef struct packed {
      logic        valid;
      logic [63:0] addrs;
      logic [31:0] ports;
      logic [63:0] tstamp;
      logic [7:0]  cmd;
      logic [3:0]  status;
      logic [31:0] stmt_id;
      logic [15:0] pcount;
   } entry_type;

   // Summary of one set against a key.
   typedef struct packed {
      logic                 hit;
      logic [WAY_IDX_W-1:0] hit_way;
      logic                 free;
      logic [WAY_IDX_W-1:0] free_way;
   } match_type;

endpackage
`default_nettype wire

### design/tcpct_set_eval.sv
`default_nettype none
module tcpct_set_eval
   import tcpct_pkg::*;
#(
   parameter int WAYS = WAYS_DEF
) (
   input  wire entry_type [WAYS-1:0] row,
   input  wire logic [63:0]          key_addrs,
   input  wire logic [31:0]          key_ports,
   output match_type                 summary
);

   // Lowest matching way and lowest free way; scan from the top so the lowest wins.
   always_comb begin
      summary = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row[w].valid && row[w].addrs == key_addrs && row[w].ports == key_ports) begin
            summary.hit     = 1'b1;
            summary.hit_way = WAY_IDX_W'(w);
         end
         if (!row[w].valid) begin
            summary.free     = 1'b1;
            summary.free_way = WAY_IDX_W'(w);
         end
      end
   end

endmodule
`default_nettype wire

### design/tcp_connection_table.sv
`default_nettype none
// Set-associative TCP connection table. After reset the block clears its set memory, one
// set per cycle, with busy high. An operation is taken when start is high and busy is low;
// busy stays high until the result beat, which appears on the rsp_ ports for one cycle
// with rsp_valid and cannot be held off. Lookup, upsert, remove and the parameter-count
// operations do one read of the set memory, then compare and write back; no new operation
// is taken until that is done. A purge walks every set, reading each in ST_PURGE_RD and
// writing it back with its stale entries cleared in ST_PURGE_WR.
module tcp_connection_table
   import tcpct_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   parameter int WAYS       = WAYS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_func,
   input  wire logic [31:0]        req_local_addr,
   input  wire logic [31:0]        req_remote_addr,
   input  wire logic [15:0]        req_local_port,
   input  wire logic [15:0]        req_remote_port,
   input  wire logic [63:0]        req_time_us,
   input  wire logic [7:0]         req_cmd,
   input  wire logic [3:0]         req_status,
   input  wire logic [31:0]        req_stmt_id,
   input  wire logic [15:0]        req_param_count,
   output logic                    rsp_valid,
   output logic                    rsp_hit,
   output logic                    rsp_inserted,
   output logic                    rsp_table_full,
   output logic [3:0]              rsp_status_out,
   output logic [63:0]             rsp_time_out,
   output logic [15:0]             rsp_param_count_out,
   output logic [COUNT_W-1:0]      rsp_removed_count,
   output logic [COUNT_W-1:0]      rsp_entry_count
);

   localparam int NUM_SETS = 1 << INDEX_BITS;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef entry_type [WAYS-1:0] row_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_PURGE_RD,
      ST_PURGE_WR
   } state_type;

   state_type               state_ff, state_in;
   logic [INDEX_BITS-1:0]   ptr_ff, ptr_in;
   logic [COUNT_W-1:0]      total_ff, total_in;
   logic [COUNT_W-1:0]      purged_ff, purged_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic                    rsp_ins_ff, rsp_ins_in;
   logic                    rsp_full_ff, rsp_full_in;
   logic [3:0]              rsp_status_ff, rsp_status_in;
   logic [63:0]             rsp_time_ff, rsp_time_in;
   logic [15:0]             rsp_pc_ff, rsp_pc_in;
   logic [COUNT_W-1:0]      rsp_removed_ff, rsp_removed_in;

   // Operation held for the duration of its work.
   logic [2:0]              func_ff;
   logic [63:0]             addrs_ff;
   logic [31:0]             ports_ff;
   logic [63:0]             time_ff;
   logic [7:0]              cmd_ff;
   logic [3:0]              status_ff;
   logic [31:0]             stmt_ff;
   logic [15:0]             pc_ff;
   logic [INDEX_BITS-1:0]   set_ff;

   row_type                 set_mem [NUM_SETS];
   row_type                 rd_row_ff;
   logic [INDEX_BITS-1:0]   rd_addr;
   logic                    mem_we;
   logic [INDEX_BITS-1:0]   wr_addr;
   row_type                 wr_row;

   logic                    accept;
   logic [31:0]             hash;
   match_type               summary;
   logic [WAY_W-1:0]        hit_way;
   logic [WAY_W-1:0]        free_way;
   row_type                 purge_row;
   logic [COUNT_W-1:0]      purge_n;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign hash   = req_local_addr ^ req_remote_addr ^ {req_local_port, req_remote_port};

   // Set memory: one row holds every way of a set.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         set_mem[wr_addr] <= wr_row;
      end
      rd_row_ff <= set_mem[rd_addr];
   end

   // Capture the operation on its start beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func;
         addrs_ff  <= {req_local_addr, req_remote_addr};
         ports_ff  <= {req_local_port, req_remote_port};
         time_ff   <= req_time_us;
         cmd_ff    <= req_cmd;
         status_ff <= req_status;
         stmt_ff   <= req_stmt_id;
         pc_ff     <= req_param_count;
         set_ff    <= hash[INDEX_BITS-1:0];
      end
   end

   tcpct_set_eval #(
      .WAYS (WAYS)
   ) u_eval (
      .row       (rd_row_ff),
      .key_addrs (addrs_ff),
      .key_ports (ports_ff),
      .summary   (summary)
   );

   assign hit_way  = summary.hit_way[WAY_W-1:0];
   assign free_way = summary.free_way[WAY_W-1:0];

   // Stale entries of the row under the purge walk.
   always_comb begin
      purge_row = rd_row_ff;
      purge_n   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (rd_row_ff[w].valid && rd_row_ff[w].tstamp < time_ff) begin
            purge_row[w].valid = 1'b0;
            purge_n            = purge_n + COUNT_W'(1);
         end
      end
   end

   // Sequencer: address selection, read-modify-write and the result beat.
   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      total_in       = total_ff;
      purged_in      = purged_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = 1'b0;
      rsp_ins_in     = 1'b0;
      rsp_full_in    = 1'b0;
      rsp_status_in  = '0;
      rsp_time_in    = '0;
      rsp_pc_in      = '0;
      rsp_removed_in = '0;
      rd_addr        = hash[INDEX_BITS-1:0];
      mem_we         = 1'b0;
      wr_addr        = set_ff;
      wr_row         = rd_row_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we  = 1'b1;
            wr_addr = ptr_ff;
            wr_row  = '0;
            ptr_in  = ptr_ff + 1'b1;
            if (&ptr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_PURGE) begin
                  state_in  = ST_PURGE_RD;
                  ptr_in    = '0;
                  purged_in = '0;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            case (func_ff)
               FUNC_LOOKUP: begin
                  if (summary.hit) begin
                     rsp_hit_in    = 1'b1;
                     rsp_status_in = rd_row_ff[hit_way].status;
                     rsp_time_in   = rd_row_ff[hit_way].tstamp;
                  end
               end
               FUNC_UPSERT: begin
                  if (summary.hit) begin
                     rsp_hit_in                 = 1'b1;
                     mem_we                     = 1'b1;
                     wr_row[hit_way].tstamp     = time_ff;
                     wr_row[hit_way].cmd        = cmd_ff;
                     if (status_ff != 4'd0) begin
                        wr_row[hit_way].status = status_ff;
                     end
                  end else if (summary.free) begin
                     rsp_ins_in                    = 1'b1;
                     mem_we                        = 1'b1;
                     wr_row[free_way].valid        = 1'b1;
                     wr_row[free_way].addrs        = addrs_ff;
                     wr_row[free_way].ports        = ports_ff;
                     wr_row[free_way].tstamp       = time_ff;
                     wr_row[free_way].cmd          = cmd_ff;
                     wr_row[free_way].status       = status_ff;
                     wr_row[free_way].stmt_id      = '0;
                     wr_row[free_way].pcount       = '0;
                     total_in                      = total_ff + 1'b1;
                  end else begin
                     rsp_full_in = 1'b1;
                  end
               end
               FUNC_REMOVE: begin
                  if (summary.hit) begin
                     rsp_hit_in             = 1'b1;
                     mem_we                 = 1'b1;
                     wr_row[hit_way].valid  = 1'b0;
                     total_in               = total_ff - 1'b1;
                  end
               end
               FUNC_SET_PC: begin
                  if (summary.hit) begin
                     rsp_hit_in                  = 1'b1;
                     mem_we                      = 1'b1;
                     wr_row[hit_way].stmt_id     = stmt_ff;
                     wr_row[hit_way].pcount      = pc_ff;
                  end
               end
               FUNC_GET_PC: begin
                  if (summary.hit) begin
                     rsp_hit_in = 1'b1;
                     rsp_pc_in  = rd_row_ff[hit_way].pcount;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_PURGE_RD: begin
            rd_addr  = ptr_ff;
            state_in = ST_PURGE_WR;
         end
         ST_PURGE_WR: begin
            mem_we    = 1'b1;
            wr_addr   = ptr_ff;
            wr_row    = purge_row;
            purged_in = purged_ff + purge_n;
            total_in  = total_ff - purge_n;
            ptr_in    = ptr_ff + 1'b1;
            if (&ptr_ff) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_removed_in = purged_ff + purge_n;
            end else begin
               state_in = ST_PURGE_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, counters and the registered result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         total_ff     <= '0;
         purged_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         total_ff     <= total_in;
         purged_ff    <= purged_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff     <= rsp_hit_in;
      rsp_ins_ff     <= rsp_ins_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_time_ff    <= rsp_time_in;
      rsp_pc_ff      <= rsp_pc_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_inserted        = rsp_ins_ff;
   assign rsp_table_full      = rsp_full_ff;
   assign rsp_status_out      = rsp_status_ff;
   assign rsp_time_out        = rsp_time_ff;
   assign rsp_param_count_out = rsp_pc_ff;
   assign rsp_removed_count   = rsp_removed_ff;
   assign rsp_entry_count     = total_ff;

   // A result beat follows only the last step of an operation.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_LOOK || $past(state_ff) == ST_PURGE_WR))
      else $error("result beat without a finishing step");

   // The set memory is never written while the block is idle.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff != ST_IDLE)
      else $error("set memory written while idle");

   // A taken operation keeps the block busy on the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after start");

   // A result beat never comes straight after an operation is taken.
   a_no_start_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !$past(accept))
      else $error("operation finished in the cycle after its start");

endmodule
`default_nettype wire

### test/tcpct_checker.sv
`default_nettype none
module tcpct_checker
   import tcpct_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [2:0]         req_func,
   input  wire logic [31:0]        req_local_addr,
   input  wire logic [31:0]        req_remote_addr,
   input  wire logic [15:0]        req_local_port,
   input  wire logic [15:0]        req_remote_port,
   input  wire logic [63:0]        req_time_us,
   input  wire logic [3:0]         req_status,
   input  wire logic [15:0]        req_param_count,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_hit,
   input  wire logic               rsp_inserted,
   input  wire logic               rsp_table_full,
   input  wire logic [3:0]         rsp_status_out,
   input  wire logic [63:0]        rsp_time_out,
   input  wire logic [15:0]        rsp_param_count_out,
   input  wire logic [COUNT_W-1:0] rsp_removed_count,
   input  wire logic [COUNT_W-1:0] rsp_entry_count,
   output int                      fail_count,
   output int                      outstanding
);

   localparam int SETS  = 1 << INDEX_BITS_DEF;
   localparam int SLOTS = SETS * WAYS_DEF;

   typedef struct {
      logic               hit;
      logic               inserted;
      logic               table_full;
      logic [3:0]         status_out;
      logic [63:0]        time_out;
      logic [15:0]        param_count_out;
      logic [COUNT_W-1:0] removed_count;
      logic [COUNT_W-1:0] entry_count;
   } conn_result_type;

   // Shadow copy of the connection table.
   logic        shadow_valid  [SLOTS];
   logic [63:0] shadow_addrs  [SLOTS];
   logic [31:0] shadow_ports  [SLOTS];
   logic [63:0] shadow_time   [SLOTS];
   logic [3:0]  shadow_status [SLOTS];
   logic [15:0] shadow_pc     [SLOTS];
   logic [COUNT_W-1:0] shadow_total;

   conn_result_type pending_results[$];

   // Applies one accepted operation to the shadow table and returns its result.
   task automatic apply_conn_op(output conn_result_type r);
      logic [31:0]  ports;
      logic [63:0]  addrs;
      logic [31:0]  h;
      int           base;
      int           found;
      int           free_slot;
      logic [COUNT_W-1:0] n;
      addrs = {req_local_addr, req_remote_addr};
      ports = {req_local_port, req_remote_port};
      h = req_local_addr ^ req_remote_addr ^ ports;
      base = int'(h[INDEX_BITS_DEF-1:0]) * WAYS_DEF;
      found = -1;
      free_slot = -1;
      for (int w = WAYS_DEF - 1; w >= 0; w--) begin
         if (shadow_valid[base+w] && shadow_addrs[base+w] == addrs &&
             shadow_ports[base+w] == ports)
            found = base + w;
         if (!shadow_valid[base+w])
            free_slot = base + w;
      end
      r = '{default: '0};
      case (req_func)
         FUNC_LOOKUP: begin
            if (found >= 0) begin
               r.hit = 1'b1;
               r.status_out = shadow_status[found];
               r.time_out = shadow_time[found];
            end
         end
         FUNC_UPSERT: begin
            if (found >= 0) begin
               r.hit = 1'b1;
               shadow_time[found] = req_time_us;
               if (req_status != 4'd0)
                  shadow_status[found] = req_status;
            end else if (free_slot < 0) begin
               r.table_full = 1'b1;
            end else begin
               shadow_valid[free_slot] = 1'b1;
               shadow_addrs[free_slot] = addrs;
               shadow_ports[free_slot] = ports;
               shadow_time[free_slot] = req_time_us;
               shadow_status[free_slot] = req_status;
               shadow_pc[free_slot] = 16'd0;
               shadow_total++;
               r.inserted = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (found >= 0) begin
               r.hit = 1'b1;
               shadow_valid[found] = 1'b0;
               shadow_total--;
            end
         end
         FUNC_PURGE: begin
            n = '0;
            for (int s = 0; s < SLOTS; s++)
               if (shadow_valid[s] && shadow_time[s] < req_time_us) begin
                  shadow_valid[s] = 1'b0;
                  n++;
               end
            shadow_total -= n;
            r.removed_count = n;
         end
         FUNC_SET_PC: begin
            if (found >= 0) begin
               r.hit = 1'b1;
               shadow_pc[found] = req_param_count;
            end
         end
         FUNC_GET_PC: begin
            if (found >= 0) begin
               r.hit = 1'b1;
               r.param_count_out = shadow_pc[found];
            end
         end
         default: ;
      endcase
      r.entry_count = shadow_total;
   endtask

   // Compare result beats first, then predict the beat taken at this edge.
   always @(posedge clock) begin
      conn_result_type e;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++)
            shadow_valid[s] = 1'b0;
         shadow_total = '0;
         pending_results.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("result beat with no operation outstanding");
               fail_count++;
            end else begin
               e = pending_results.pop_front();
               if (rsp_hit !== e.hit) begin
                  $error("hit: expected %0d, got %0d", e.hit, rsp_hit);
                  fail_count++;
               end
               if (rsp_inserted !== e.inserted) begin
                  $error("inserted: expected %0d, got %0d", e.inserted, rsp_inserted);
                  fail_count++;
               end
               if (rsp_table_full !== e.table_full) begin
                  $error("table_full: expected %0d, got %0d", e.table_full, rsp_table_full);
                  fail_count++;
               end
               if (rsp_status_out !== e.status_out) begin
                  $error("status_out: expected %0d, got %0d", e.status_out, rsp_status_out);
                  fail_count++;
               end
               if (rsp_time_out !== e.time_out) begin
                  $error("time_out: expected %0h, got %0h", e.time_out, rsp_time_out);
                  fail_count++;
               end
               if (rsp_param_count_out !== e.param_count_out) begin
                  $error("param_count_out: expected %0d, got %0d", e.param_count_out,
                         rsp_param_count_out);
                  fail_count++;
               end
               if (rsp_removed_count !== e.removed_count) begin
                  $error("removed_count: expected %0d, got %0d", e.removed_count,
                         rsp_removed_count);
                  fail_count++;
               end
               if (rsp_entry_count !== e.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", e.entry_count,
                         rsp_entry_count);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            apply_conn_op(e);
            pending_results.push_back(e);
         end
      end
      outstanding = pending_results.size();
   end

endmodule
`default_nettype wire

### test/tb_tcp_connection_table.sv
`default_nettype none
module tb_tcp_connection_table;
   import tcpct_pkg::*;

   localparam int POOL = 48;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0]  req_func = '0;
   logic [31:0] req_local_addr = '0;
   logic [31:0] req_remote_addr = '0;
   logic [15:0] req_local_port = '0;
   logic [15:0] req_remote_port = '0;
   logic [63:0] req_time_us = '0;
   logic [7:0]  req_cmd = '0;
   logic [3:0]  req_status = '0;
   logic [31:0] req_stmt_id = '0;
   logic [15:0] req_param_count = '0;
   logic               rsp_valid, rsp_hit, rsp_inserted, rsp_table_full;
   logic [3:0]         rsp_status_out;
   logic [63:0]        rsp_time_out;
   logic [15:0]        rsp_param_count_out;
   logic [COUNT_W-1:0] rsp_removed_count, rsp_entry_count;
   int fail_count, outstanding;
   int cycle_count = 0;
   bit idle_on = 1'b1;

   // Keys in groups of six that share one set, so sets can be filled past WAYS.
   logic [31:0] key_la [POOL];
   logic [31:0] key_ra [POOL];
   logic [15:0] key_lp [POOL];
   logic [15:0] key_rp [POOL];

   tcp_connection_table uut (.*);
   tcpct_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit; purges dominate the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("tcp_connection_table test failed");
         $finish;
      end
   end

   // Drives one operation beat and holds it until the block takes it.
   task automatic issue_op(input logic [2:0] f, input int k, input logic [63:0] t,
                           input logic [3:0] s);
      while (idle_on && $urandom_range(0, 99) < 37) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_func <= f;
      req_local_addr <= key_la[k];
      req_remote_addr <= key_ra[k];
      req_local_port <= key_lp[k];
      req_remote_port <= key_rp[k];
      req_time_us <= t;
      req_cmd <= 8'($urandom);
      req_status <= s;
      req_stmt_id <= $urandom;
      req_param_count <= 16'($urandom);
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_pending();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   initial begin
      int k;
      int sel;
      logic [2:0] f;
      logic [63:0] t;
      for (int g = 0; g < POOL / 6; g++) begin
         key_la[g*6] = $urandom;
         key_ra[g*6] = $urandom;
         key_lp[g*6] = 16'($urandom);
         key_rp[g*6] = 16'($urandom);
         for (int j = 1; j < 6; j++) begin
            key_la[g*6+j] = key_la[g*6];
            key_ra[g*6+j] = key_ra[g*6];
            key_lp[g*6+j] = key_lp[g*6];
            key_rp[g*6+j] = key_rp[g*6] ^ 16'(j << INDEX_BITS_DEF);
         end
      end
      // Two fixed keys at the extremes of the key fields.
      key_la[0] = '0; key_ra[0] = '0; key_lp[0] = '0; key_rp[0] = '0;
      key_la[6] = '1; key_ra[6] = '1; key_lp[6] = '1; key_rp[6] = '1;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: miss, insert, update, parameter counts, full set, removes, unused codes, purges.
      issue_op(FUNC_LOOKUP, 0, '0, 4'd0);
      issue_op(FUNC_UPSERT, 0, '1, 4'd15);
      issue_op(FUNC_UPSERT, 0, '1, 4'd0);
      issue_op(FUNC_LOOKUP, 0, '0, 4'd0);
      issue_op(FUNC_SET_PC, 0, '0, 4'd0);
      issue_op(FUNC_GET_PC, 0, '0, 4'd0);
      for (int j = 0; j < 6; j++)
         issue_op(FUNC_UPSERT, 6 + j, 64'(j * 7), 4'(j + 1));
      issue_op(FUNC_LOOKUP, 11, '0, 4'd0);
      issue_op(FUNC_REMOVE, 7, '0, 4'd0);
      issue_op(FUNC_REMOVE, 7, '0, 4'd0);
      issue_op(FUNC_GET_PC, 7, '0, 4'd0);
      issue_op(FUNC_SET_PC, 7, '0, 4'd0);
      issue_op(FUNC_UPSERT, 11, 64'd3, 4'd0);
      issue_op(3'd6, 6, '0, 4'd0);
      issue_op(3'd7, 6, '0, 4'd0);
      issue_op(FUNC_PURGE, 0, '0, 4'd0);
      issue_op(FUNC_PURGE, 0, 64'd10, 4'd0);
      issue_op(FUNC_PURGE, 0, '1, 4'd0);
      drain_pending();

      // Random traffic, mostly over the key pool so entries get hit and sets fill.
      for (int i = 0; i < 900; i++) begin
         idle_on = !(i >= 300 && i < 500);
         if (i == 450)
            drain_pending();
         k = $urandom_range(0, POOL - 1);
         if ($urandom_range(0, 99) < 15) begin
            key_la[k] = $urandom;
            key_ra[k] = $urandom;
            key_lp[k] = 16'($urandom);
            key_rp[k] = 16'($urandom);
         end
         sel = $urandom_range(0, 99);
         if (sel < 20)      f = FUNC_LOOKUP;
         else if (sel < 52) f = FUNC_UPSERT;
         else if (sel < 64) f = FUNC_REMOVE;
         else if (sel < 67) f = FUNC_PURGE;
         else if (sel < 80) f = FUNC_SET_PC;
         else if (sel < 97) f = FUNC_GET_PC;
         else               f = 3'($urandom_range(6, 7));
         if ($urandom_range(0, 99) < 6)
            t = {$urandom, $urandom};
         else
            t = 64'($urandom_range(0, f == FUNC_PURGE ? 400 : 1000));
         issue_op(f, k, t, 4'($urandom));
      end
      drain_pending();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("tcp_connection_table test passed");
      else
         $display("tcp_connection_table test failed");
      $finish;
   end

endmodule
`default_nettype wire
